/* design/ispd_pkg.sv */
// ispd_pkg: shared types and constants for the icon stream pixel doubler
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package ispd_pkg;

   localparam logic       KIND_DIM        = 1'b0;
   localparam logic       KIND_PIXEL      = 1'b1;
   localparam logic [1:0] REP_ONE         = 2'd1;
   localparam logic [1:0] REP_TWO         = 2'd2;
   localparam logic [7:0] SCALE_DOUBLE    = 8'd2;
   localparam logic [7:0] SCALE_RESET     = 8'd1;
   localparam int         DOUBLE_WIDTH_MAX = 32;
   localparam int         CSR_ADDR_W      = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SCALE = 3'd0;
   localparam logic [2:0] HDR_WIDTH_LO    = 3'd0;
   localparam logic [2:0] HDR_WIDTH_HI    = 3'd1;
   localparam logic [2:0] HDR_HEIGHT_LO   = 3'd2;
   localparam logic [2:0] HDR_HEIGHT_HI   = 3'd3;

   typedef struct packed {
      logic take;
      logic rep_start;
      logic rep_issue;
      logic rep_load;
   } cmd_type;

   typedef struct packed {
      logic in_item;
      logic in_replay;
      logic rep_last;
   } status_type;

endpackage

`default_nettype wire

/* design/ispd_if.sv */
// ispd_req_if / ispd_rsp_if: valid-ready channels of the pixel doubler
// depends on nothing but the handshake; payload widths fixed by the item format
`default_nettype none

interface ispd_req_if;
   logic       valid;
   logic       ready;
   logic       first_byte;
   logic [7:0] data_byte;
   modport source (output valid, output first_byte, output data_byte, input ready);
   modport sink   (input valid, input first_byte, input data_byte, output ready);
endinterface

interface ispd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] pixel_color;
   logic [1:0]  repeat_res;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        last;
   modport source (output valid, output kind, output pixel_color, output repeat_res,
                   output image_width, output image_height, output last, input ready);
   modport sink   (input valid, input kind, input pixel_color, input repeat_res,
                   input image_width, input image_height, input last, output ready);
endinterface

`default_nettype wire

/* design/ispd_ctrl.sv */
// ispd_ctrl: handshake and row replay sequencer of the pixel doubler
// depends on ispd_pkg (command and status structs)
`default_nettype none

module ispd_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   input  wire ispd_pkg::status_type status,
   output ispd_pkg::cmd_type         cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       loaded;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      loaded        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               cmd.take = 1'b1;
               loaded   = status.in_item;
               if (status.in_replay) begin
                  cmd.rep_start = 1'b1;
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rep_issue = 1'b1;
            state_in      = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               cmd.rep_load = 1'b1;
               loaded       = 1'b1;
               state_in     = status.rep_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (loaded)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* design/ispd_datapath.sv */
// ispd_datapath: header parse, pixel pairing, row store and result register
// depends on ispd_pkg; driven by ispd_ctrl commands
`default_nettype none

module ispd_datapath #(
   parameter int LINE_BUFFER_DEPTH = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire [7:0]                 scale,
   input  wire ispd_pkg::cmd_type    cmd,
   output ispd_pkg::status_type      status,
   input  wire                       in_first_byte,
   input  wire [7:0]                 in_data_byte,
   output logic                      out_kind,
   output logic [15:0]               out_pixel_color,
   output logic [1:0]                out_repeat_res,
   output logic [15:0]               out_image_width,
   output logic [15:0]               out_image_height,
   output logic                      out_last
);

   localparam int AW = (LINE_BUFFER_DEPTH > 1) ? $clog2(LINE_BUFFER_DEPTH) : 1;

   logic [2:0]  header_count_ff;
   logic [15:0] source_width_ff;
   logic [7:0]  source_height_low_ff;
   logic        double_active_ff;
   logic        pair_phase_ff, pair_phase_in;
   logic [7:0]  high_byte_hold_ff;
   logic [5:0]  column_count_ff, column_count_in;
   logic [5:0]  rep_idx_ff;
   logic [15:0] rd_data_ff;
   logic [15:0] row_store [LINE_BUFFER_DEPTH];

   logic        kind_ff;
   logic [15:0] color_ff, width_ff, height_ff;
   logic [1:0]  rep_ff;
   logic        last_ff;

   logic [2:0]  hc_eff;
   logic        pp_eff;
   logic [5:0]  col_eff, col_next;
   logic        hdr, is_pix, row_done, dbl_now;
   logic [15:0] height_full;

   assign hc_eff   = in_first_byte ? 3'd0 : header_count_ff;
   assign pp_eff   = in_first_byte ? 1'b0 : pair_phase_ff;
   assign col_eff  = in_first_byte ? 6'd0 : column_count_ff;
   assign col_next = col_eff + 6'd1;
   assign hdr      = !hc_eff[2];
   assign is_pix   = !hdr && pp_eff;
   assign row_done = double_active_ff && (16'(col_next) >= source_width_ff);
   assign dbl_now  = (scale == ispd_pkg::SCALE_DOUBLE)
                     && (source_width_ff <= 16'(ispd_pkg::DOUBLE_WIDTH_MAX))
                     && (17'(source_width_ff) <= 17'(LINE_BUFFER_DEPTH));
   assign height_full = {in_data_byte, source_height_low_ff};

   assign status.in_item   = (hdr && hc_eff == ispd_pkg::HDR_HEIGHT_HI) || is_pix;
   assign status.in_replay = is_pix && row_done && (source_width_ff != 16'd0);
   assign status.rep_last  = (16'(rep_idx_ff) + 16'd1) >= source_width_ff;

   always_comb begin
      pair_phase_in   = pp_eff;
      column_count_in = col_eff;
      if (hdr) begin
         if (hc_eff == ispd_pkg::HDR_HEIGHT_HI) begin
            pair_phase_in   = 1'b0;
            column_count_in = 6'd0;
         end
      end else if (!pp_eff) begin
         pair_phase_in = 1'b1;
      end else begin
         pair_phase_in = 1'b0;
         if (double_active_ff)
            column_count_in = row_done ? 6'd0 : col_next;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff      <= 3'd0;
         source_width_ff      <= 16'd0;
         source_height_low_ff <= 8'd0;
         double_active_ff     <= 1'b0;
         pair_phase_ff        <= 1'b0;
         high_byte_hold_ff    <= 8'd0;
         column_count_ff      <= 6'd0;
      end else if (cmd.take) begin
         pair_phase_ff   <= pair_phase_in;
         column_count_ff <= column_count_in;
         if (hdr) begin
            header_count_ff <= hc_eff + 3'd1;
            case (hc_eff)
               ispd_pkg::HDR_WIDTH_LO:  source_width_ff[7:0]  <= in_data_byte;
               ispd_pkg::HDR_WIDTH_HI:  source_width_ff[15:8] <= in_data_byte;
               ispd_pkg::HDR_HEIGHT_LO: source_height_low_ff  <= in_data_byte;
               default:                 double_active_ff      <= dbl_now;
            endcase
         end else if (!pp_eff) begin
            high_byte_hold_ff <= in_data_byte;
         end
      end
   end

   // row store
   always_ff @(posedge clock) begin
      if (cmd.take && is_pix && double_active_ff
          && (9'(col_eff) < 9'(LINE_BUFFER_DEPTH)))
         row_store[AW'(col_eff)] <= {high_byte_hold_ff, in_data_byte};
      if (cmd.rep_issue)
         rd_data_ff <= row_store[AW'(rep_idx_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rep_idx_ff <= 6'd0;
      else if (cmd.rep_start)
         rep_idx_ff <= 6'd0;
      else if (cmd.rep_load)
         rep_idx_ff <= rep_idx_ff + 6'd1;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.take && status.in_item) begin
         if (hdr) begin
            kind_ff   <= ispd_pkg::KIND_DIM;
            color_ff  <= 16'd0;
            rep_ff    <= ispd_pkg::REP_ONE;
            width_ff  <= dbl_now ? {source_width_ff[14:0], 1'b0} : source_width_ff;
            height_ff <= dbl_now ? {height_full[14:0], 1'b0} : height_full;
            last_ff   <= 1'b1;
         end else begin
            kind_ff   <= ispd_pkg::KIND_PIXEL;
            color_ff  <= {high_byte_hold_ff, in_data_byte};
            rep_ff    <= double_active_ff ? ispd_pkg::REP_TWO : ispd_pkg::REP_ONE;
            width_ff  <= 16'd0;
            height_ff <= 16'd0;
            last_ff   <= !status.in_replay;
         end
      end else if (cmd.rep_load) begin
         kind_ff   <= ispd_pkg::KIND_PIXEL;
         color_ff  <= rd_data_ff;
         rep_ff    <= ispd_pkg::REP_TWO;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
         last_ff   <= status.rep_last;
      end
   end

   assign out_kind         = kind_ff;
   assign out_pixel_color  = color_ff;
   assign out_repeat_res   = rep_ff;
   assign out_image_width  = width_ff;
   assign out_image_height = height_ff;
   assign out_last         = last_ff;

endmodule

`default_nettype wire

/* design/icon_stream_pixel_doubler_core.sv */
// icon_stream_pixel_doubler_core: top level, csr register and channel wiring
// depends on ispd_pkg, ispd_if, ispd_ctrl and ispd_datapath
//
// Takes an icon file one byte per item: a four byte little-endian width and
// height header, then big-endian RGB565 pixel pairs. Writing 2 to the scale
// register (offset 0, reset 1) doubles icons up to 32 pixels wide: each
// pixel goes out with repeat 2 and every finished source row is replayed
// from the row store. A byte is taken whenever the result register is free
// and no replay runs; each replayed pixel is first read from the row store
// into a register, then loaded into the result register once it is free. No
// input byte is taken during a replay.
`default_nettype none

module icon_stream_pixel_doubler_core #(
   parameter int LINE_BUFFER_DEPTH = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   ispd_req_if.sink                          req_ch,
   ispd_rsp_if.source                        rsp_ch,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire [ispd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire [31:0]                        csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [7:0]           scale_ff;
   ispd_pkg::cmd_type    cmd;
   ispd_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset)
         scale_ff <= ispd_pkg::SCALE_RESET;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr == ispd_pkg::CSR_ADDR_SCALE)
         scale_ff <= csr_pwdata[7:0];
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr == ispd_pkg::CSR_ADDR_SCALE) ? {24'd0, scale_ff} : 32'd0;

   ispd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ispd_datapath #(
      .LINE_BUFFER_DEPTH (LINE_BUFFER_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .scale            (scale_ff),
      .cmd              (cmd),
      .status           (status),
      .in_first_byte    (req_ch.first_byte),
      .in_data_byte     (req_ch.data_byte),
      .out_kind         (rsp_ch.kind),
      .out_pixel_color  (rsp_ch.pixel_color),
      .out_repeat_res   (rsp_ch.repeat_res),
      .out_image_width  (rsp_ch.image_width),
      .out_image_height (rsp_ch.image_height),
      .out_last         (rsp_ch.last)
   );

endmodule

`default_nettype wire

/* test/icon_stream_pixel_doubler_core_test.sv */
// testbench for icon_stream_pixel_doubler_core: icon byte streams with random
// idling on both channels, each result checked against an in-bench upscaler
// depends on ispd_pkg, ispd_if and the core
`timescale 1ns / 100ps

module icon_stream_pixel_doubler_core_test;

   localparam int ROW_DEPTH      = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 36;

   typedef struct packed {
      logic        kind;
      logic [15:0] color;
      logic [1:0]  rep;
      logic [15:0] width;
      logic [15:0] height;
      logic        last;
   } display_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [ispd_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]                     csr_pwdata  = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   ispd_req_if req();
   ispd_rsp_if rsp();

   icon_stream_pixel_doubler_core #(
      .LINE_BUFFER_DEPTH(ROW_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req),
      .rsp_ch     (rsp),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #5 clock = ~clock;

   // upscaler state
   logic [7:0]    scale_reg     = ispd_pkg::SCALE_RESET;
   logic [2:0]    hdr_count     = '0;
   logic [15:0]   src_width     = '0;
   logic [7:0]    src_height_lo = '0;
   logic          doubling      = 1'b0;
   logic          low_byte_next = 1'b0;
   logic [7:0]    high_hold     = '0;
   logic [5:0]    col_count     = '0;
   logic [15:0]   row_mem [ROW_DEPTH];

   display_item_type pending_items[$];
   int               mismatches      = 0;
   int               items_sent      = 0;
   int               results_checked = 0;
   int               files_sent      = 0;
   bit               gaps_on         = 1'b1;

   initial begin
      foreach (row_mem[i]) row_mem[i] = '0;
   end

   function automatic display_item_type make_item(input logic kind,
                                                  input logic [15:0] color,
                                                  input logic [1:0] rep,
                                                  input logic [15:0] w,
                                                  input logic [15:0] h);
      display_item_type it;
      it.kind   = kind;
      it.color  = color;
      it.rep    = rep;
      it.width  = w;
      it.height = h;
      it.last   = 1'b0;
      return it;
   endfunction

   task automatic upscale_byte(input logic mark, input logic [7:0] b);
      display_item_type batch[$];
      logic [15:0]      w;
      logic [15:0]      h;
      logic [15:0]      color;
      int               c;
      if (mark) begin
         hdr_count     = '0;
         low_byte_next = 1'b0;
         col_count     = '0;
      end
      if (hdr_count < 4) begin
         case (hdr_count)
            ispd_pkg::HDR_WIDTH_LO: src_width[7:0] = b;
            ispd_pkg::HDR_WIDTH_HI: src_width[15:8] = b;
            ispd_pkg::HDR_HEIGHT_LO: src_height_lo = b;
            default: begin
               w = src_width;
               h = {b, src_height_lo};
               doubling = (scale_reg == ispd_pkg::SCALE_DOUBLE)
                          && (src_width <= ispd_pkg::DOUBLE_WIDTH_MAX)
                          && (src_width <= ROW_DEPTH);
               if (doubling) begin
                  w = w << 1;
                  h = h << 1;
               end
               low_byte_next = 1'b0;
               col_count     = '0;
               batch.push_back(make_item(ispd_pkg::KIND_DIM, 16'h0000, ispd_pkg::REP_ONE,
                                         w, h));
            end
         endcase
         hdr_count = hdr_count + 3'd1;
      end else if (!low_byte_next) begin
         high_hold     = b;
         low_byte_next = 1'b1;
      end else begin
         color         = {high_hold, b};
         low_byte_next = 1'b0;
         if (!doubling) begin
            batch.push_back(make_item(ispd_pkg::KIND_PIXEL, color, ispd_pkg::REP_ONE,
                                      16'h0000, 16'h0000));
         end else begin
            c = col_count;
            if (c < ROW_DEPTH) row_mem[c] = color;
            batch.push_back(make_item(ispd_pkg::KIND_PIXEL, color, ispd_pkg::REP_TWO,
                                      16'h0000, 16'h0000));
            c++;
            if (c >= src_width) begin
               for (int x = 0; x < src_width && x < ROW_DEPTH; x++)
                  batch.push_back(make_item(ispd_pkg::KIND_PIXEL, row_mem[x],
                                            ispd_pkg::REP_TWO, 16'h0000, 16'h0000));
               c = 0;
            end
            col_count = c[5:0];
         end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_items.push_back(batch[i]);
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
   endtask

   // result check first, then prediction of the item taken at the same edge
   always @(posedge clock) begin
      display_item_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         results_checked++;
         if (pending_items.size() == 0) begin
            report_mismatch("result with none pending", rsp.pixel_color, 16'h0000);
         end else begin
            want = pending_items.pop_front();
            if (rsp.kind !== want.kind)
               report_mismatch("kind", 16'(rsp.kind), 16'(want.kind));
            if (rsp.pixel_color !== want.color)
               report_mismatch("pixel_color", rsp.pixel_color, want.color);
            if (rsp.repeat_res !== want.rep)
               report_mismatch("repeat_res", 16'(rsp.repeat_res), 16'(want.rep));
            if (rsp.image_width !== want.width)
               report_mismatch("image_width", rsp.image_width, want.width);
            if (rsp.image_height !== want.height)
               report_mismatch("image_height", rsp.image_height, want.height);
            if (rsp.last !== want.last)
               report_mismatch("last", 16'(rsp.last), 16'(want.last));
         end
      end
      if (!reset && req.valid && req.ready) upscale_byte(req.first_byte, req.data_byte);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   initial begin
      int g;
      rsp.ready = 1'b1;
      forever begin
         repeat ($urandom_range(1, 8)) @(negedge clock);
         g = pick_gap();
         if (g > 0) begin
            rsp.ready = 1'b0;
            repeat (g) @(negedge clock);
            rsp.ready = 1'b1;
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr_psel && csr_penable))
            idle = 0;
         else
            idle++;
      end
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   task automatic send_item(input logic mark, input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid      = 1'b1;
      req.first_byte = mark;
      req.data_byte  = b;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic settle();
      req.valid = 1'b0;
      while (pending_items.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic check_scale_readback();
      logic [31:0] got;
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = ispd_pkg::CSR_ADDR_SCALE;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      if (got[7:0] !== scale_reg)
         report_mismatch("scale register readback", {8'h00, got[7:0]}, {8'h00, scale_reg});
   endtask

   task automatic change_scale(input logic [7:0] value);
      settle();
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ispd_pkg::CSR_ADDR_SCALE;
      csr_pwdata  = {24'($urandom), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      scale_reg = value;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      check_scale_readback();
   endtask

   task automatic test_register_reset();
      check_scale_readback();
   endtask

   // header taken right after reset without the first-byte mark
   task automatic test_header_without_mark();
      send_item(1'b0, 8'h01);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'hFF);
   endtask

   // doubled row with replay, height wrapping
   task automatic test_double_extremes();
      change_scale(ispd_pkg::SCALE_DOUBLE);
      send_item(1'b1, 8'h02);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hA5);
      send_item(1'b0, 8'h5A);
   endtask

   // zero width while doubling, then a lone high byte left waiting
   task automatic test_zero_width_and_odd_byte();
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h80);
      send_item(1'b0, 8'h7E);
      send_item(1'b0, 8'h81);
      send_item(1'b0, 8'h3C);
   endtask

   // new file over the waiting byte; too wide to double
   task automatic test_wide_icon();
      send_item(1'b1, 8'h21);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h01);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h12);
      send_item(1'b0, 8'h34);
   endtask

   function automatic logic [15:0] pick_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 16'd0;
      if (r < 55) return 16'($urandom_range(1, 4));
      if (r < 80) return 16'($urandom_range(5, 16));
      if (r < 88) return 16'($urandom_range(17, 31));
      if (r < 94) return 16'(ispd_pkg::DOUBLE_WIDTH_MAX);
      if (r < 97) return 16'($urandom_range(33, 40));
      return 16'($urandom);
   endfunction

   task automatic send_random_chunk();
      int          r;
      int          n;
      logic [15:0] w;
      logic [15:0] h;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         w = pick_width();
         h = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 4)) : 16'($urandom);
         if (w == 0) n = $urandom_range(0, 3);
         else if (w > ispd_pkg::DOUBLE_WIDTH_MAX) n = $urandom_range(0, 6);
         else n = w * $urandom_range(1, 3);
         if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
         send_item(1'b1, w[7:0]);
         send_item(1'b0, w[15:8]);
         send_item(1'b0, h[7:0]);
         send_item(1'b0, h[15:8]);
         repeat (2 * n) send_item(1'b0, 8'($urandom));
         files_sent++;
      end else if (r < 92) begin
         repeat ($urandom_range(1, 5)) send_item($urandom_range(0, 5) == 0, 8'($urandom));
      end else begin
         send_item(1'b0, 8'($urandom));
      end
   endtask

   task automatic test_random_files();
      logic [7:0] settings[6];
      int         start;
      settings = '{8'd0, 8'd255, ispd_pkg::SCALE_DOUBLE, ispd_pkg::SCALE_RESET,
                   8'($urandom), ispd_pkg::SCALE_DOUBLE};
      foreach (settings[p]) begin
         change_scale(settings[p]);
         gaps_on = (p != 2);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) send_random_chunk();
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      req.valid      = 1'b0;
      req.first_byte = 1'b0;
      req.data_byte  = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_register_reset();
      test_header_without_mark();
      test_double_extremes();
      test_zero_width_and_odd_byte();
      test_wide_icon();
      test_random_files();
      settle();
      repeat (20) @(negedge clock);
      $display("sent %0d bytes in %0d random files plus directed cases, six scale settings",
               items_sent, files_sent);
      $display("checked %0d results, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0 && pending_items.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* icon_stream_pixel_doubler_core.f */
design/ispd_pkg.sv
design/ispd_if.sv
design/ispd_ctrl.sv
design/ispd_datapath.sv
design/icon_stream_pixel_doubler_core.sv
test/icon_stream_pixel_doubler_core_test.sv
